// File: src/tph_pkg.sv
package tph_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_NOT_TCP   = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_READOUT   = 3'd4
    } status_t;

    // Destination port classes
    typedef enum logic [1:0] {
        PC_HTTP  = 2'd0,
        PC_HTTPS = 2'd1,
        PC_OTHER = 2'd2
    } port_class_t;

    // Configuration register indexes
    localparam logic [1:0] REG_BUCKET_WIDTH = 2'd0;
    localparam logic [1:0] REG_BUCKET_COUNT = 2'd1;
    localparam logic [1:0] REG_LEAD_BUCKETS = 2'd2;

    localparam logic [40:0] WIDTH_RESET = 41'd1000000;
    localparam logic [10:0] COUNT_RESET = 11'd600;
    localparam logic [10:0] LEAD_RESET  = 11'd60;

    localparam logic [15:0] PORT_WEB    = 16'd80;
    localparam logic [15:0] PORT_SECURE = 16'd443;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
    localparam logic [15:0] MIN_LEN_V4  = 16'd40;
    localparam logic [15:0] MIN_LEN_V6  = 16'd60;

    // Packet summary handed from the byte parser to the binning engine
    typedef struct packed {
        logic [63:0] ptime;
        logic        is_tcp;
        logic [15:0] dport;
    } pkt_sum_t;

endpackage

// File: src/tph_parser.sv
module tph_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           data_byte,
    input  logic                 first,
    input  logic                 last,
    input  logic [31:0]          ts_seconds,
    input  logic [19:0]          ts_micros,
    output logic                 done,
    output tph_pkg::pkt_sum_t    summary
);
    logic [15:0] pos_reg, pos_next;
    logic [3:0]  ver_reg, ver_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] dport_reg, dport_next;
    logic [63:0] ptime_reg, ptime_next;
    logic [15:0] p;
    logic [15:0] caplen;
    logic        tcp;

    always_comb begin
        pos_next   = pos_reg;
        ver_next   = ver_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        ptime_next = ptime_reg;
        p          = pos_reg;
        if (first) begin
            p          = '0;
            ver_next   = '0;
            proto_next = '0;
            dport_next = '0;
            // seconds times 10^6: 32x20 multiply
            ptime_next = 64'(ts_seconds * MICROS_PER_SEC_64()) + 64'(ts_micros);
        end
        if (p == 16'd0) ver_next = data_byte[7:4];
        if (ver_next == 4'd4) begin
            if (p == 16'd9) proto_next = data_byte;
            else if (p == 16'd22) dport_next = {data_byte, dport_next[7:0]};
            else if (p == 16'd23) dport_next = {dport_next[15:8], data_byte};
        end else if (ver_next == 4'd6) begin
            if (p == 16'd6) proto_next = data_byte;
            else if (p == 16'd42) dport_next = {data_byte, dport_next[7:0]};
            else if (p == 16'd43) dport_next = {dport_next[15:8], data_byte};
        end
        caplen = (p != 16'hFFFF) ? p + 16'd1 : p;
        pos_next = last ? 16'd0 : caplen;
        if (ver_next == 4'd4)
            tcp = caplen >= tph_pkg::MIN_LEN_V4 && proto_next == tph_pkg::PROTO_TCP;
        else if (ver_next == 4'd6)
            tcp = caplen >= tph_pkg::MIN_LEN_V6 && proto_next == tph_pkg::PROTO_TCP;
        else
            tcp = 1'b0;
    end

    function automatic logic [63:0] MICROS_PER_SEC_64();
        return 64'(tph_pkg::MICROS_PER_SEC);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            ver_reg   <= '0;
            proto_reg <= '0;
            dport_reg <= '0;
            ptime_reg <= '0;
            done      <= 1'b0;
        end else begin
            done <= byte_en && last;
            if (byte_en) begin
                pos_reg   <= pos_next;
                ver_reg   <= ver_next;
                proto_reg <= proto_next;
                dport_reg <= dport_next;
                ptime_reg <= ptime_next;
                summary.ptime  <= ptime_next;
                summary.is_tcp <= tcp;
                summary.dport  <= dport_next;
            end
        end
    end
endmodule

// File: src/tph_divider.sv
module tph_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [40:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    // restoring divide, one quotient bit per cycle
    logic [63:0] q_reg;
    logic [41:0] r_reg;
    logic [40:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [41:0] shifted;
    logic [42:0] trial;

    assign shifted  = {r_reg[40:0], q_reg[63]};
    assign trial    = {1'b0, shifted} - {2'b00, d_reg};
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                if (!trial[42]) begin
                    r_reg <= trial[41:0];
                    q_reg <= {q_reg[62:0], 1'b1};
                end else begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

// File: src/tph_counts.sv
module tph_counts #(
    parameter int BUCKETS    = 1024,
    parameter int COUNT_BITS = 32,
    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    output logic                  clear_busy,
    input  logic                  rd_en,
    input  logic [IW-1:0]         rd_addr,
    output logic [COUNT_BITS-1:0] rd_http,
    output logic [COUNT_BITS-1:0] rd_https,
    output logic [COUNT_BITS-1:0] rd_other,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_addr,
    input  logic [COUNT_BITS-1:0] wr_http,
    input  logic [COUNT_BITS-1:0] wr_https,
    input  logic [COUNT_BITS-1:0] wr_other
);
    logic [3*COUNT_BITS-1:0] mem [BUCKETS];
    logic [3*COUNT_BITS-1:0] rd_q;
    logic [IW-1:0] clr_reg;
    logic          clr_busy_reg;

    assign clear_busy = clr_busy_reg;
    assign {rd_other, rd_https, rd_http} = rd_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_reg      <= '0;
        end else if (clr_busy_reg) begin
            clr_reg <= clr_reg + IW'(1);
            if (clr_reg == IW'(BUCKETS - 1)) clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg)
            mem[clr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= {wr_other, wr_https, wr_http};
        if (rd_en) rd_q <= mem[rd_addr];
    end
endmodule

// File: src/tcp_port_time_histogram.sv
// Time-binned TCP histogram. Packet bytes stream in on s_axis with the capture
// time on the first byte; a read word (tuser bit 0 set) returns one bucket.
// Each packet's last byte or a read yields one m_axis word; other bytes none.
// Packet bytes are taken one per cycle while s_tready is high until a last
// byte. The bucket lookup then runs a 64-step bit-serial divide and a
// read-modify-write of the count memory. s_tready stays low after a counted
// packet's last byte while the packet summary is registered, the base is
// checked, the divide runs, the count is read and the count is written back.
// An underflow holds the input through the base check and an overflow through
// the divide. A result word that is not taken holds the input until it is.
// After reset the count memory is cleared by a sweep over all BUCKETS entries
// before any word is accepted.
module tcp_port_time_histogram #(
    parameter int BUCKETS    = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [39:8] ts_seconds, [59:40] ts_micros, [69:60] read_index
    input  logic [71:0] s_tdata,
    input  logic        s_tlast,   // last
    // [0] func, [1] first
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [12:3] bucket_index, [14:13] port_class, [46:15] http_total,
    // [78:47] https_total, [110:79] other_total, [142:111] underflow_total,
    // [174:143] overflow_total
    output logic [175:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BASE = 6'b000010,
        S_DIV  = 6'b000100,
        S_RD   = 6'b001000,
        S_WR   = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [40:0] width_reg;
    logic [10:0] count_reg, lead_reg;
    logic [63:0] base_reg;
    logic        started_reg;
    logic [COUNT_BITS-1:0] under_reg, over_reg;
    logic        rdout_reg;
    logic [9:0]  ridx_reg;
    logic [2:0]  st_reg;
    logic [1:0]  cls_reg;
    logic [63:0] lead_prod_reg;

    logic [175:0] out_reg;
    logic        out_valid_reg;

    logic        clear_busy;
    logic        s_acc, byte_en, func;
    logic        pdone, ddone;
    tph_pkg::pkt_sum_t summ;
    logic [63:0] quot;
    logic [40:0] width_eff;
    logic [63:0] diff;
    logic        div_start;
    logic [IW-1:0] idx;
    logic [COUNT_BITS-1:0] rh, rs, ro, wh, ws, wo;
    logic        rd_en;
    logic [IW-1:0] rd_addr;
    logic        in_range;

    assign width_eff = (width_reg == '0) ? 41'd1 : width_reg;
    assign func      = s_tuser[0];
    // hold the input while a packet end is handed from the parser
    assign s_tready  = state_reg == S_IDLE && !clear_busy && !out_valid_reg && !pdone;
    assign s_acc     = s_tvalid && s_tready;
    assign byte_en   = s_acc && !func;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    tph_parser u_parser (
        .aclk, .aresetn, .byte_en,
        .data_byte (s_tdata[7:0]),
        .first     (s_tuser[1]),
        .last      (s_tlast),
        .ts_seconds(s_tdata[39:8]),
        .ts_micros (s_tdata[59:40]),
        .done      (pdone),
        .summary   (summ)
    );

    // base time is set at most once, so diff only uses the settled base
    assign diff = summ.ptime - base_reg;
    assign div_start = state_reg == S_BASE && !(!base_reg[63] && base_reg > summ.ptime);

    tph_divider u_div (
        .aclk, .aresetn,
        .start   (div_start),
        .dividend(diff),
        .divisor (width_eff),
        .done    (ddone),
        .quotient(quot)
    );

    assign in_range = quot < 64'(count_reg) && quot < 64'(BUCKETS);
    assign idx      = rdout_reg ? IW'(ridx_reg) : quot[IW-1:0];
    assign rd_en    = (state_reg == S_DIV && ddone) || (s_acc && func);
    assign rd_addr  = (s_acc && func) ? IW'(s_tdata[69:60]) : quot[IW-1:0];

    tph_counts #(.BUCKETS(BUCKETS), .COUNT_BITS(COUNT_BITS)) u_counts (
        .aclk, .aresetn, .clear_busy,
        .rd_en, .rd_addr,
        .rd_http(rh), .rd_https(rs), .rd_other(ro),
        .wr_en  (state_reg == S_RD && st_reg == tph_pkg::ST_COUNTED),
        .wr_addr(idx),
        .wr_http(wh), .wr_https(ws), .wr_other(wo)
    );

    always_comb begin
        wh = rh; ws = rs; wo = ro;
        case (cls_reg)
            tph_pkg::PC_HTTP:  wh = (rh != CMAX) ? rh + 1'b1 : rh;
            tph_pkg::PC_HTTPS: ws = (rs != CMAX) ? rs + 1'b1 : rs;
            default:           wo = (ro != CMAX) ? ro + 1'b1 : ro;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (pdone) state_next = S_BASE;
                    else if (s_acc && func) state_next = S_RD;
            S_BASE: state_next = div_start ? S_DIV : S_OUT;
            S_DIV:  if (ddone) state_next = in_range ? S_RD : S_OUT;
            S_RD:   state_next = S_WR;
            S_WR:   state_next = S_IDLE;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic ok_slot;
    assign ok_slot = !rdout_reg || ({22'd0, ridx_reg} < 32'(BUCKETS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            width_reg   <= tph_pkg::WIDTH_RESET;
            count_reg   <= tph_pkg::COUNT_RESET;
            lead_reg    <= tph_pkg::LEAD_RESET;
            base_reg    <= '0;
            started_reg <= 1'b0;
            under_reg   <= '0;
            over_reg    <= '0;
            out_valid_reg <= 1'b0;
            rdout_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            lead_prod_reg <= 64'(width_eff) * 64'(lead_reg);
            if (cfg_valid) begin
                case (cfg_index)
                    tph_pkg::REG_BUCKET_WIDTH: width_reg <= cfg_data[40:0];
                    tph_pkg::REG_BUCKET_COUNT: count_reg <= cfg_data[10:0];
                    tph_pkg::REG_LEAD_BUCKETS: lead_reg  <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (s_acc && func) begin
                rdout_reg <= 1'b1;
                ridx_reg  <= s_tdata[69:60];
                st_reg    <= tph_pkg::ST_READOUT;
                cls_reg   <= tph_pkg::PC_HTTP;
            end
            if (pdone) begin
                rdout_reg <= 1'b0;
                if (!started_reg) begin
                    base_reg    <= summ.ptime - lead_prod_reg;
                    started_reg <= 1'b1;
                end
            end
            if (state_reg == S_BASE && !div_start) begin
                under_reg <= (under_reg != CMAX) ? under_reg + 1'b1 : under_reg;
                out_reg <= {1'b0, 32'(over_reg),
                            32'((under_reg != CMAX) ? under_reg + 1'b1 : under_reg),
                            96'd0, 2'd0, 10'd0, tph_pkg::ST_UNDERFLOW};
                out_valid_reg <= 1'b1;
            end
            if (state_reg == S_DIV && ddone) begin
                if (!in_range) begin
                    over_reg <= (over_reg != CMAX) ? over_reg + 1'b1 : over_reg;
                    out_reg <= {1'b0,
                                32'((over_reg != CMAX) ? over_reg + 1'b1 : over_reg),
                                32'(under_reg), 96'd0, 2'd0, 10'd0, tph_pkg::ST_OVERFLOW};
                    out_valid_reg <= 1'b1;
                end else if (!summ.is_tcp) begin
                    st_reg <= tph_pkg::ST_NOT_TCP; cls_reg <= tph_pkg::PC_HTTP;
                end else begin
                    st_reg <= tph_pkg::ST_COUNTED;
                    cls_reg <= (summ.dport == tph_pkg::PORT_WEB) ? tph_pkg::PC_HTTP :
                               (summ.dport == tph_pkg::PORT_SECURE) ? tph_pkg::PC_HTTPS :
                               tph_pkg::PC_OTHER;
                end
            end
            if (state_reg == S_RD) begin
                // read data is valid now; show updated counts for a counted packet
                out_reg <= {1'b0, 32'(over_reg), 32'(under_reg),
                            ok_slot ? 32'(st_reg == tph_pkg::ST_COUNTED ? wo : ro) : 32'd0,
                            ok_slot ? 32'(st_reg == tph_pkg::ST_COUNTED ? ws : rs) : 32'd0,
                            ok_slot ? 32'(st_reg == tph_pkg::ST_COUNTED ? wh : rh) : 32'd0,
                            cls_reg, rdout_reg ? ridx_reg : 10'(quot), st_reg};
                out_valid_reg <= 1'b1;
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !s_tready) else $error("input taken while result stalled");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready) else $error("accept during clear");
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> state_reg == S_DIV) else $error("divide not tracked");
endmodule

// File: dv/tcp_port_time_histogram_test.sv
`timescale 1ns / 100ps

module tcp_port_time_histogram_test;

    localparam int  NBKT       = 1024;
    localparam int  DRAIN_WAIT = 120;
    localparam longint LIMIT   = 400000;
    localparam longint USEC    = 1000000;

    // Histogram predictor and store of expected result words
    class hist_scoreboard;
        bit [40:0] width_r = tph_pkg::WIDTH_RESET;
        bit [10:0] count_r = tph_pkg::COUNT_RESET;
        bit [10:0] lead_r  = tph_pkg::LEAD_RESET;
        bit [31:0] http_c [NBKT];
        bit [31:0] https_c[NBKT];
        bit [31:0] other_c[NBKT];
        bit [63:0] base_t;
        bit        started;
        bit [31:0] under_n, over_n;
        bit [15:0] pos;
        bit [3:0]  ver;
        bit [7:0]  proto;
        bit [15:0] dport;
        bit [63:0] ptime;
        bit [175:0] pending_words[$];
        int errors;
        int words_seen;

        function new();
            foreach (http_c[i]) begin
                http_c[i] = 0; https_c[i] = 0; other_c[i] = 0;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function bit [31:0] bump(bit [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function bit [63:0] eff_width();
            return (width_r == 0) ? 64'd1 : 64'(width_r);
        endfunction

        function void queue_word(tph_pkg::status_t st, bit [9:0] idx,
                                 tph_pkg::port_class_t pc, int slot, bit has_slot);
            bit [31:0] h, s, o;
            bit [175:0] word;
            h = 0; s = 0; o = 0;
            if (has_slot && slot < NBKT) begin
                h = http_c[slot]; s = https_c[slot]; o = other_c[slot];
            end
            word = {1'b0, over_n, under_n, o, s, h, pc, idx, st};
            pending_words.insert(pending_words.size(), word);
        endfunction

        function void note_word(bit func, bit [7:0] b, bit first, bit last,
                                bit [31:0] sec, bit [19:0] us, bit [9:0] ridx);
            bit [15:0] caplen;
            bit [63:0] w, diff, idx;
            bit tcp;
            if (func) begin
                queue_word(tph_pkg::ST_READOUT, ridx, tph_pkg::PC_HTTP, int'(ridx), 1);
                return;
            end
            if (first) begin
                pos = 0; ver = 0; proto = 0; dport = 0;
                ptime = 64'(sec) * 64'(USEC) + 64'(us);
            end
            if (pos == 0) ver = b[7:4];
            if (ver == 4) begin
                if (pos == 9) proto = b;
                else if (pos == 22) dport[15:8] = b;
                else if (pos == 23) dport[7:0] = b;
            end else if (ver == 6) begin
                if (pos == 6) proto = b;
                else if (pos == 42) dport[15:8] = b;
                else if (pos == 43) dport[7:0] = b;
            end
            if (pos != 16'hFFFF) pos++;
            if (!last) return;
            caplen = pos;
            pos = 0;
            w = eff_width();
            if (!started) begin
                base_t = ptime - w * 64'(lead_r);
                started = 1;
            end
            // a base before time zero is never after any packet
            if (!base_t[63] && base_t > ptime) begin
                under_n = bump(under_n);
                queue_word(tph_pkg::ST_UNDERFLOW, 10'd0, tph_pkg::PC_HTTP, 0, 0);
                return;
            end
            diff = ptime - base_t;
            idx = diff / w;
            if (idx >= 64'(count_r) || idx >= NBKT) begin
                over_n = bump(over_n);
                queue_word(tph_pkg::ST_OVERFLOW, 10'd0, tph_pkg::PC_HTTP, 0, 0);
                return;
            end
            if (ver == 4)
                tcp = caplen >= tph_pkg::MIN_LEN_V4 && proto == tph_pkg::PROTO_TCP;
            else if (ver == 6)
                tcp = caplen >= tph_pkg::MIN_LEN_V6 && proto == tph_pkg::PROTO_TCP;
            else tcp = 0;
            if (!tcp) begin
                queue_word(tph_pkg::ST_NOT_TCP, idx[9:0], tph_pkg::PC_HTTP, int'(idx), 1);
            end else if (dport == tph_pkg::PORT_WEB) begin
                http_c[idx] = bump(http_c[idx]);
                queue_word(tph_pkg::ST_COUNTED, idx[9:0], tph_pkg::PC_HTTP, int'(idx), 1);
            end else if (dport == tph_pkg::PORT_SECURE) begin
                https_c[idx] = bump(https_c[idx]);
                queue_word(tph_pkg::ST_COUNTED, idx[9:0], tph_pkg::PC_HTTPS, int'(idx), 1);
            end else begin
                other_c[idx] = bump(other_c[idx]);
                queue_word(tph_pkg::ST_COUNTED, idx[9:0], tph_pkg::PC_OTHER, int'(idx), 1);
            end
        endfunction

        task check_word(bit [175:0] got);
            bit [175:0] want, mask;
            int lo[8] = '{0, 3, 13, 15, 47, 79, 111, 143};
            int wd[8] = '{3, 10, 2, 32, 32, 32, 32, 32};
            string nm[8] = '{"status", "bucket_index", "port_class", "http_total",
                             "https_total", "other_total", "underflow_total",
                             "overflow_total"};
            words_seen++;
            if (pending_words.size() == 0) begin
                report($sformatf("result word with nothing expected: %h", got));
                return;
            end
            want = pending_words.pop_front();
            for (int i = 0; i < 8; i++) begin
                mask = (176'd1 << wd[i]) - 176'd1;
                if (((got >> lo[i]) & mask) != ((want >> lo[i]) & mask))
                    report($sformatf("word %0d %s got %0h want %0h", words_seen, nm[i],
                                     (got >> lo[i]) & mask, (want >> lo[i]) & mask));
            end
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         s_tlast;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    hist_scoreboard sb = new();
    bit     quiet;          // no idling on either side while set
    int     out_hold = 0;
    longint cycles = 0;
    int     packet_words;

    tcp_port_time_histogram DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run as failed once the cycle counter passes LIMIT
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check each accepted word, then stall at random unless quiet is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
                out_hold = quiet ? 0 : $urandom_range(0, 4);
            end
            if (out_hold > 0) begin
                m_tready <= 1'b0;
                out_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Drive one input word; leave tvalid high so back-to-back words need no gap
    task send_word(bit func, bit [7:0] b, bit first, bit last,
                   bit [31:0] sec, bit [19:0] us, bit [9:0] ridx);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ridx, us, sec, b};
        s_tlast  <= last;
        s_tuser  <= {first, func};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(func, b, first, last, sec, us, ridx);
        if (!func) packet_words++;
    endtask

    // Lower tvalid and wait until every expected word is back, plus the tail
    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tph_pkg::REG_BUCKET_WIDTH: sb.width_r = val[40:0];
            tph_pkg::REG_BUCKET_COUNT: sb.count_r = val[10:0];
            tph_pkg::REG_LEAD_BUCKETS: sb.lead_r  = val[10:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task set_window(logic [63:0] w, logic [63:0] cnt, logic [63:0] lead);
        drain_results();
        write_reg(tph_pkg::REG_BUCKET_WIDTH, w);
        write_reg(tph_pkg::REG_BUCKET_COUNT, cnt);
        write_reg(tph_pkg::REG_LEAD_BUCKETS, lead);
    endtask

    task read_bucket(bit [9:0] idx);
        send_word(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), $urandom,
                  20'($urandom), idx);
    endtask

    // Stream one packet; header fields placed per IP version
    task send_packet(int ver, int len, bit [7:0] proto, bit [15:0] port,
                     bit [31:0] sec, bit [19:0] us, bit mark_first, bit mark_last);
        bit [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == 0) b[7:4] = ver[3:0];
            if (ver == 4) begin
                if (i == 9) b = proto;
                else if (i == 22) b = port[15:8];
                else if (i == 23) b = port[7:0];
            end else if (ver == 6) begin
                if (i == 6) b = proto;
                else if (i == 42) b = port[15:8];
                else if (i == 43) b = port[7:0];
            end
            if (i == 0) send_word(1'b0, b, mark_first, mark_last && i == len - 1,
                                  sec, us, 10'($urandom));
            else send_word(1'b0, b, 1'b0, mark_last && i == len - 1,
                           $urandom, 20'($urandom), 10'($urandom));
        end
    endtask

    // Capture time landing near bucket k of the current window
    task pick_time(int k, output bit [31:0] sec, output bit [19:0] us);
        longint t, w;
        bit [63:0] r;
        w = longint'(sb.eff_width());
        r = {$urandom, $urandom};
        if (!sb.started) t = 100 * USEC;
        else t = longint'(sb.base_t) + longint'(k) * w + longint'(r % 64'(w));
        if (t < 0) t = 0;
        if (t / USEC > 64'hFFFF_FFFF) begin
            sec = 32'hFFFF_FFFF;
            us  = 20'd999999;
        end else begin
            sec = 32'(t / USEC);
            us  = 20'(t % USEC);
        end
    endtask

    task random_packet();
        int r, k, ver, len;
        bit [7:0] proto;
        bit [15:0] port;
        bit [31:0] sec;
        bit [19:0] us;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, int'(sb.count_r) + 3) - 2;
        pick_time(k, sec, us);
        ver = $urandom_range(0, 1) ? 4 : 6;
        proto = ($urandom_range(0, 9) != 0) ? tph_pkg::PROTO_TCP : 8'($urandom);
        case ($urandom_range(0, 2))
            0: port = tph_pkg::PORT_WEB;
            1: port = tph_pkg::PORT_SECURE;
            default: port = 16'($urandom);
        endcase
        if (r < 10) begin
            read_bucket(10'($urandom));
        end else if (r < 80) begin
            len = (ver == 4) ? $urandom_range(40, 48) : $urandom_range(60, 66);
            send_packet(ver, len, proto, port, sec, us, 1, 1);
        end else if (r < 88) begin
            len = (ver == 4) ? $urandom_range(1, 39) : $urandom_range(1, 59);
            send_packet(ver, len, proto, port, sec, us, 1, 1);
        end else if (r < 93) begin
            do ver = $urandom_range(0, 15); while (ver == 4 || ver == 6);
            send_packet(ver, $urandom_range(20, 70), proto, port, sec, us, 1, 1);
        end else begin
            // bytes without a first mark continue the current packet
            send_packet($urandom_range(0, 15), $urandom_range(1, 30), proto, port,
                        sec, us, 0, 1'($urandom_range(0, 1)));
        end
    endtask

    task run_traffic(int n_words, int n_results, bit hold_midway);
        int start_words, start_results;
        bit paused;
        start_words = packet_words;
        start_results = sb.words_seen + sb.pending_words.size();
        paused = 0;
        while (packet_words - start_words < n_words ||
               sb.words_seen + sb.pending_words.size() - start_results < n_results) begin
            random_packet();
            if (hold_midway && !paused && packet_words - start_words > n_words / 2) begin
                // hold off until every expected word has come back
                paused = 1;
                s_tvalid <= 1'b0;
                while (sb.pending_words.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
        end
    endtask

    initial begin
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tlast   = 0;
        s_tuser   = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 0;
        packet_words = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first packet fixes the base 60 buckets before 100 s
        send_packet(4, 40, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 100, 0, 1, 1);
        send_packet(6, 60, tph_pkg::PROTO_TCP, tph_pkg::PORT_SECURE, 100, 999999, 1, 1);
        send_packet(4, 44, tph_pkg::PROTO_TCP, 16'hFFFF, 130, 5, 1, 1);
        send_packet(4, 40, 8'd17, tph_pkg::PORT_WEB, 100, 0, 1, 1);
        send_packet(4, 39, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 100, 0, 1, 1);
        send_packet(6, 59, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 100, 0, 1, 1);
        send_packet(5, 64, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 100, 0, 1, 1);
        send_packet(4, 40, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 0, 0, 1, 1);
        send_packet(4, 40, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 32'hFFFF_FFFF, 999999, 1, 1);
        send_packet(4, 40, tph_pkg::PROTO_TCP, 16'h0000, 39, 999999, 1, 1);
        send_packet(4, 10, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 101, 0, 1, 0);
        send_packet(4, 35, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 0, 0, 0, 1);
        send_packet(6, 70, tph_pkg::PROTO_TCP, tph_pkg::PORT_WEB, 0, 0, 0, 1);
        read_bucket(0);
        read_bucket(60);
        read_bucket(700);
        read_bucket(10'h3FF);
        read_bucket(61);

        // Random phases across window settings
        run_traffic(60, 3, 1);
        set_window(1000, 1024, 1024);
        run_traffic(20, 1, 0);
        set_window(0, 0, 0);
        run_traffic(20, 1, 0);
        set_window(64'd1099511627776, 1, 5);
        run_traffic(20, 1, 0);
        quiet = 1;
        set_window(50, 2047, 2047);
        run_traffic(20, 1, 0);
        quiet = 0;
        set_window(1, 1024, 0);
        run_traffic(20, 1, 0);
        set_window(1000000, 600, 60);
        run_traffic(20, 1, 0);

        drain_results();
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
